// ----- rtl/core/aigd_pkg.sv -----
package aigd_pkg;

  // Field widths fixed by the stream format
  localparam int CountW     = 29;
  localparam int ByteW      = 8;
  localparam int PayloadW   = 7;
  localparam int PosW       = 3;
  localparam int LitBitsDef = 31;

  // Label is 2*(count+count+1): one bit wider than the sum
  localparam int SumW   = CountW + 1;
  localparam int LabelW = SumW + 1;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegInputCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGateCount  = 1'b1;

  // Saturation byte position: pos stops here and any payload at it is overflow
  localparam logic [PosW-1:0] PosSat = 3'd7;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_NEGATIVE = 2'd2,
    ERR_NOT_LESS = 2'd3
  } err_t;

endpackage

// ----- rtl/core/aig_and_delta_decoder.sv -----
// Channel | Ports                                              | Direction
// in      | in_valid, in_stall, in_data_byte                   | byte in
// out     | out_valid, out_stall, out_gate_literal, out_first_input,
//         | out_second_input, out_error_code, out_last_gate    | gate out
// cfg     | cfg_we, cfg_idx, cfg_wdata                         | write only
//
// One byte is taken every cycle while in_stall is low. A byte that ends the
// second delta of a pair puts the pair into the decode stage; its result
// passes from there through the output register to the out channel. The
// decode stage and the output register form a two-entry pipe, so in_stall
// rises only while both hold an item and out_stall is high. Reset (rst_n,
// synchronous) clears the configuration, the delta state and both valid flags.
module aig_and_delta_decoder #(
  parameter int LITERAL_BITS = aigd_pkg::LitBitsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // byte input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [aigd_pkg::ByteW-1:0]       in_data_byte,
  // gate output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [LITERAL_BITS-1:0]          out_gate_literal,
  output logic [LITERAL_BITS-1:0]          out_first_input,
  output logic [LITERAL_BITS-1:0]          out_second_input,
  output logic [1:0]                       out_error_code,
  output logic                             out_last_gate,
  // configuration
  input  logic                             cfg_we,
  input  logic [aigd_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [aigd_pkg::CountW-1:0]      cfg_wdata
);

  localparam int LB  = LITERAL_BITS;
  // shifted payload: highest payload bit at 7*6+6 = 48
  localparam int SHW = LB + 49;
  // compare width: holds both a full label and any delta
  localparam int XW  = (LB >= aigd_pkg::LabelW) ? LB + 1 : aigd_pkg::LabelW + 1;

  // configuration registers
  logic [aigd_pkg::CountW-1:0] input_count_r;
  logic [aigd_pkg::CountW-1:0] gate_count_r;

  // delta gathering state
  logic [LB-1:0]                 acc_r, acc_nxt;
  logic [aigd_pkg::PosW-1:0]     pos_r, pos_nxt;
  logic [LB-1:0]                 delta0_r, delta0_nxt;
  logic                          second_half_r, second_half_nxt;
  logic [aigd_pkg::CountW-1:0]   gate_idx_r, gate_idx_nxt;
  logic                          ovf_r, ovf_nxt;

  // decode stage
  logic                          s1_vld_r, s1_vld_nxt;
  logic [LB-1:0]                 s1_d0_r, s1_d1_r;
  logic                          s1_ovf_r;
  logic [aigd_pkg::LabelW-1:0]   s1_label_r;
  logic                          s1_last_r;

  // output register
  logic                          out_vld_r;
  logic [LB-1:0]                 out_label_r, out_first_r, out_second_r;
  aigd_pkg::err_t                out_err_r;
  logic                          out_last_r;

  // handshake
  logic in_acc, out_adv, s1_adv, pair_done;

  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_adv   = s1_vld_r && out_adv;
  assign in_stall = s1_vld_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r <= '0;
      gate_count_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        aigd_pkg::RegInputCount: input_count_r <= cfg_wdata;
        aigd_pkg::RegGateCount:  gate_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload placement at 7*pos
  logic [aigd_pkg::PayloadW-1:0] payload;
  logic                          cont;
  logic [5:0]                    sh_amt;
  logic [SHW-1:0]                shifted;
  logic                          ovf_add;
  logic [LB-1:0]                 acc_new;
  logic                          ovf_new;

  always_comb begin
    payload = in_data_byte[aigd_pkg::PayloadW-1:0];
    cont    = in_data_byte[aigd_pkg::ByteW-1];
    sh_amt  = {pos_r, 3'b000} - {3'b000, pos_r};
    shifted = SHW'(payload) << sh_amt;
    if (pos_r != aigd_pkg::PosSat) begin
      ovf_add = |shifted[SHW-1:LB];
      acc_new = acc_r | shifted[LB-1:0];
    end else begin
      ovf_add = |payload;
      acc_new = acc_r;
    end
    ovf_new = ovf_r | ovf_add;
  end

  // label and last flag for the gate in progress
  logic [aigd_pkg::SumW-1:0] label_sum;
  logic                      is_last;

  assign label_sum = aigd_pkg::SumW'(input_count_r) + aigd_pkg::SumW'(gate_idx_r)
                   + aigd_pkg::SumW'(1);
  assign is_last   = (gate_count_r != '0)
                  && (gate_idx_r == gate_count_r - aigd_pkg::CountW'(1));

  // delta state next values
  always_comb begin
    acc_nxt         = acc_r;
    pos_nxt         = pos_r;
    delta0_nxt      = delta0_r;
    second_half_nxt = second_half_r;
    gate_idx_nxt    = gate_idx_r;
    ovf_nxt         = ovf_r;
    pair_done       = 1'b0;
    if (in_acc) begin
      if (cont) begin
        acc_nxt = acc_new;
        ovf_nxt = ovf_new;
        if (pos_r != aigd_pkg::PosSat) begin
          pos_nxt = pos_r + aigd_pkg::PosW'(1);
        end
      end else if (!second_half_r) begin
        delta0_nxt      = acc_new;
        second_half_nxt = 1'b1;
        acc_nxt         = '0;
        pos_nxt         = '0;
        ovf_nxt         = ovf_new;
      end else begin
        pair_done       = 1'b1;
        delta0_nxt      = '0;
        second_half_nxt = 1'b0;
        acc_nxt         = '0;
        pos_nxt         = '0;
        ovf_nxt         = 1'b0;
        gate_idx_nxt    = gate_idx_r + aigd_pkg::CountW'(1);
      end
    end
    s1_vld_nxt = (s1_vld_r && !s1_adv) || pair_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      pos_r         <= '0;
      delta0_r      <= '0;
      second_half_r <= 1'b0;
      gate_idx_r    <= '0;
      ovf_r         <= 1'b0;
      s1_vld_r      <= 1'b0;
    end else begin
      acc_r         <= acc_nxt;
      pos_r         <= pos_nxt;
      delta0_r      <= delta0_nxt;
      second_half_r <= second_half_nxt;
      gate_idx_r    <= gate_idx_nxt;
      ovf_r         <= ovf_nxt;
      s1_vld_r      <= s1_vld_nxt;
    end
  end

  // decode stage payload
  always_ff @(posedge clk) begin
    if (pair_done) begin
      s1_d0_r    <= delta0_r;
      s1_d1_r    <= acc_new;
      s1_ovf_r   <= ovf_new;
      s1_label_r <= {label_sum, 1'b0};
      s1_last_r  <= is_last;
    end
  end

  // subtractions and error checks
  logic [XW-1:0]   label_x, d0_x, d1_x, first_x, second_x;
  logic            label_ovf, negative;
  logic [LB-1:0]   res_label, res_first, res_second;
  aigd_pkg::err_t  res_err;

  always_comb begin
    label_x   = XW'(s1_label_r);
    d0_x      = XW'(s1_d0_r);
    d1_x      = XW'(s1_d1_r);
    first_x   = label_x - d0_x;
    second_x  = first_x - d1_x;
    label_ovf = (label_x >> LB) != '0;
    negative  = (d0_x > label_x) || (d1_x > first_x);
    res_label  = label_x[LB-1:0];
    res_first  = '0;
    res_second = '0;
    res_err    = aigd_pkg::ERR_NONE;
    if (label_ovf) begin
      res_err   = aigd_pkg::ERR_OVERFLOW;
      res_label = '0;
    end else if (s1_ovf_r) begin
      res_err = aigd_pkg::ERR_OVERFLOW;
    end else if (negative) begin
      res_err = aigd_pkg::ERR_NEGATIVE;
    end else begin
      res_first  = first_x[LB-1:0];
      res_second = second_x[LB-1:0];
      if (s1_d0_r == '0) begin
        res_err = aigd_pkg::ERR_NOT_LESS;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_label_r  <= res_label;
      out_first_r  <= res_first;
      out_second_r <= res_second;
      out_err_r    <= res_err;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_gate_literal = out_label_r;
  assign out_first_input  = out_first_r;
  assign out_second_input = out_second_r;
  assign out_error_code   = out_err_r;
  assign out_last_gate    = out_last_r;

endmodule
